FILE: sv/bdws_pkg.sv
// shared types, constants and blank classification for the word selector
package bdws_pkg;

  localparam int unsigned WordIndexBits = 16;
  localparam int unsigned WordNumBits   = 16;
  localparam int unsigned CmpBits       = (WordIndexBits > WordNumBits) ?
                                          WordIndexBits : WordNumBits;
  localparam int unsigned CpBits        = 21;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrBits  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntBits  = $clog2(QueueDepth + 1);

  localparam logic [WordNumBits-1:0] WordNumReset = WordNumBits'(1);

  localparam logic [CpBits-1:0] CpTab        = CpBits'(32'h0009);
  localparam logic [CpBits-1:0] CpCr         = CpBits'(32'h000d);
  localparam logic [CpBits-1:0] CpSpace      = CpBits'(32'h0020);
  localparam logic [CpBits-1:0] CpNel        = CpBits'(32'h0085);
  localparam logic [CpBits-1:0] CpNbsp       = CpBits'(32'h00a0);
  localparam logic [CpBits-1:0] CpOgham      = CpBits'(32'h1680);
  localparam logic [CpBits-1:0] CpEnQuad     = CpBits'(32'h2000);
  localparam logic [CpBits-1:0] CpHairSpace  = CpBits'(32'h200a);
  localparam logic [CpBits-1:0] CpLineSep    = CpBits'(32'h2028);
  localparam logic [CpBits-1:0] CpParaSep    = CpBits'(32'h2029);
  localparam logic [CpBits-1:0] CpNarrowNbsp = CpBits'(32'h202f);
  localparam logic [CpBits-1:0] CpMathSpace  = CpBits'(32'h205f);
  localparam logic [CpBits-1:0] CpIdeoSpace  = CpBits'(32'h3000);

  typedef struct packed {
    logic [CpBits-1:0] codepoint;
    logic              last_in_string;
  } in_t;

  typedef struct packed {
    logic [CpBits-1:0] out_codepoint;
    logic              selected;
    logic              blank;
    logic              end_of_string;
    logic              word_found;
  } out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [CpBits-1:0] codepoint;
    logic              last_in_string;
    logic              blank;
  } class_t;

  function automatic logic is_blank(input logic [CpBits-1:0] cp);
    return (cp >= CpTab && cp <= CpCr) || cp == CpSpace ||
           cp == CpNel || cp == CpNbsp || cp == CpOgham ||
           (cp >= CpEnQuad && cp <= CpHairSpace) ||
           cp == CpLineSep || cp == CpParaSep || cp == CpNarrowNbsp ||
           cp == CpMathSpace || cp == CpIdeoSpace;
  endfunction

endpackage

FILE: sv/bdws_front.sv
// front end: accepts input words and classifies blanks
module bdws_front (
  input  bdws_pkg::in_t    in_word_i,
  input  logic             push_i,
  input  logic             q_full_i,
  output logic             full_o,
  output logic             q_push_o,
  output bdws_pkg::class_t q_word_o
);
  import bdws_pkg::*;

  assign full_o   = q_full_i;
  assign q_push_o = push_i & ~q_full_i;

  always_comb begin
    q_word_o.codepoint      = in_word_i.codepoint;
    q_word_o.last_in_string = in_word_i.last_in_string;
    q_word_o.blank          = is_blank(in_word_i.codepoint);
  end

endmodule

FILE: sv/bdws_queue.sv
// short queue of classified words between front and back
module bdws_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bdws_pkg::class_t wdata_i,
  input  logic             pop_i,
  output bdws_pkg::class_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import bdws_pkg::*;

  class_t                  mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QueueCntBits-1:0] cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntBits'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [QueuePtrBits-1:0] ptr_inc(input logic [QueuePtrBits-1:0] p);
    return (p == QueuePtrBits'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wptr_d = do_push ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = do_pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/bdws_back.sv
// back end: word counting, selection and result register
module bdws_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bdws_pkg::WordNumBits-1:0] word_number_i,
  input  bdws_pkg::class_t                 q_word_i,
  input  logic                             q_empty_i,
  output logic                             q_pop_o,
  output bdws_pkg::out_t                   out_word_o,
  output logic                             empty_o,
  input  logic                             pop_i
);
  import bdws_pkg::*;

  logic [WordIndexBits-1:0] words_seen_q, words_seen_d;
  logic                     inside_q, inside_d;
  logic                     target_q, target_d;
  logic                     marking_q, marking_d;
  logic                     out_valid_q, out_valid_d;
  out_t                     out_q, out_d;
  logic                     take, new_word, counted, match;
  logic [WordIndexBits-1:0] words_inc;

  // result slot frees up in the same cycle it is popped
  assign take    = ~q_empty_i & (~out_valid_q | pop_i);
  assign q_pop_o = take;

  assign new_word  = ~q_word_i.blank & ~inside_q;
  assign counted   = (words_seen_q != '1);
  assign words_inc = words_seen_q + 1'b1;
  assign match     = counted & ~target_q &
                     (CmpBits'(words_inc) == CmpBits'(word_number_i));

  always_comb begin
    words_seen_d = words_seen_q;
    inside_d     = inside_q;
    target_d     = target_q;
    marking_d    = marking_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & ~pop_i;
    if (take) begin
      out_valid_d = 1'b1;
      if (q_word_i.blank) begin
        inside_d  = 1'b0;
        marking_d = 1'b0;
      end else if (new_word) begin
        if (counted) begin
          words_seen_d = words_inc;
        end
        inside_d  = 1'b1;
        marking_d = match;
        if (match) begin
          target_d = 1'b1;
        end
      end
      out_d.out_codepoint = q_word_i.codepoint;
      out_d.blank         = q_word_i.blank;
      out_d.end_of_string = q_word_i.last_in_string;
      out_d.selected      = ~q_word_i.blank & (new_word ? match : marking_q);
      out_d.word_found    = q_word_i.last_in_string & target_d;
      if (q_word_i.last_in_string) begin
        words_seen_d = '0;
        inside_d     = 1'b0;
        target_d     = 1'b0;
        marking_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_seen_q <= '0;
      inside_q     <= 1'b0;
      target_q     <= 1'b0;
      marking_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      words_seen_q <= words_seen_d;
      inside_q     <= inside_d;
      target_q     <= target_d;
      marking_q    <= marking_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_word_o = out_q;
  assign empty_o    = ~out_valid_q;

  // a selected codepoint is never a blank
  a_sel_not_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.selected && out_q.blank))
    else $error("selected blank codepoint");

  // found flag only on the end of string
  a_found_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.word_found |-> out_q.end_of_string)
    else $error("word_found away from end of string");

  // scan state is cleared after the last codepoint
  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && q_word_i.last_in_string |=>
      (words_seen_q == '0) && !inside_q && !target_q && !marking_q)
    else $error("scan state not cleared after end of string");

  // marking only within a word whose start was the target
  a_marking_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    marking_q |-> target_q && inside_q)
    else $error("marking outside the target word");

  // a stalled result holds
  a_result_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

endmodule

FILE: sv/blank_delimited_word_selector_core.sv
// top level of the blank-delimited word selector
// Streams a string one codepoint per word (last codepoint flagged) and marks
// every codepoint of the blank-delimited word whose one-based number is held
// in the word_number register (reset value 1); the result for the last
// codepoint also says whether that word was present. Throughput is one word
// per cycle on both sides while the result side is not stalled; a pushed word
// passes two registers, the classification queue and then the result
// register, before it shows on the output. The front end classifies
// blanks and feeds a two-entry queue, so a stalled consumer does not stop
// input until that queue fills.
// word_number may only be written while the block holds no pending words.
module blank_delimited_word_selector_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input queue side
  input  bdws_pkg::in_t                    in_word_i,
  input  logic                             push,
  output logic                             full,
  // result queue side
  output bdws_pkg::out_t                   out_word_o,
  output logic                             empty,
  input  logic                             pop,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [bdws_pkg::WordNumBits-1:0] cfg_wdata_i
);
  import bdws_pkg::*;

  logic [WordNumBits-1:0] word_number_q;
  logic                   q_push, q_pop, q_full, q_empty;
  class_t                 q_wdata, q_rdata;

  // word number register, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_number_q <= WordNumReset;
    end else if (cfg_we_i) begin
      word_number_q <= cfg_wdata_i;
    end
  end

  // classify and accept
  bdws_front u_front (
    .in_word_i (in_word_i),
    .push_i    (push),
    .q_full_i  (q_full),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_word_o  (q_wdata)
  );

  // decouples front and back
  bdws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // word counting and result register
  bdws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_number_i (word_number_q),
    .q_word_i      (q_rdata),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .out_word_o    (out_word_o),
    .empty_o       (empty),
    .pop_i         (pop)
  );

endmodule
